@@ sv/rc4_pkg.sv @@
`timescale 1ns / 1ps

package rc4_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_SCHEDULE = 2'd1;
   localparam logic [1:0] CMD_GENERATE = 2'd2;

   // last permutation index, end of the key schedule sweep
   localparam logic [7:0] LAST_INDEX = 8'd255;

   // key_length after reset
   localparam logic [8:0] KEY_LENGTH_RESET = 9'd16;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KS_READ_I,
      ST_KS_READ_J,
      ST_KS_WRITE_J,
      ST_KS_WRITE_I,
      ST_GEN_READ_I,
      ST_GEN_READ_J,
      ST_GEN_WRITE_J,
      ST_GEN_WRITE_I,
      ST_GEN_READ_SEL,
      ST_GEN_OUT
   } state_type;

endpackage

@@ sv/rc4_keystream_generator.sv @@
`timescale 1ns / 1ps

// RC4 keystream generator. Each request carries a command in req_tuser: load
// writes key_byte into the key store at key_index, schedule resets the state
// table to the identity and runs the 256-step key schedule over the first
// key_length key bytes (0 counts as 1, values above MAX_KEY_BYTES saturate),
// generate returns one keystream byte on rsp_tdata for the caller to XOR with
// its data. Only generate gives a response transfer. A new request is taken
// only while the sequencer is idle. All of it goes through one state table with
// a separate write port and a registered read port, so every swap costs a read
// of each entry and two separate writes. Key bytes must be loaded before a
// schedule uses them. The user must write key_length on the csr port only while
// no request is in work; the block itself does not enforce it.
module rc4_keystream_generator
   import rc4_pkg::*;
#(
   parameter int MAX_KEY_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_index [7:0], key_byte [15:8]
   input  logic [1:0]  req_tuser,   // command [1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // keystream_byte [7:0]
   // key_length register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);

   localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam logic [8:0] MAX_LEN    = 9'(MAX_KEY_BYTES);
   localparam logic [8:0] MAX_LEN_M1 = 9'(MAX_KEY_BYTES - 1);

   // storage
   logic [7:0] perm_mem [256];
   logic [7:0] key_mem  [MAX_KEY_BYTES];
   logic [255:0] perm_valid_ff;

   // sequencer and datapath registers
   state_type state_ff, state_in;
   logic [7:0] i_ff, i_in;
   logic [7:0] j_ff, j_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [KW-1:0] kpos_ff, kpos_in;
   logic [7:0] si_ff, si_in;
   logic [7:0] sj_ff, sj_in;
   logic [8:0] key_length_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   // registered read side of the state table
   logic [7:0] perm_rdata_ff;
   logic       perm_rvld_ff;
   logic [7:0] perm_raddr_ff;
   logic [7:0] key_rdata_ff;

   // table controls
   logic       perm_re;
   logic [7:0] perm_raddr;
   logic       perm_we;
   logic [7:0] perm_waddr;
   logic [7:0] perm_wdata;
   logic       perm_clear;

   logic       req_xfer;
   logic [1:0] req_cmd;
   logic [7:0] req_key_index;
   logic [7:0] req_key_byte;
   logic       key_we;
   logic [7:0] perm_value;
   logic [8:0] len_m1;
   logic       kpos_last;
   logic       rsp_free;

   assign req_cmd       = req_tuser;
   assign req_key_index = req_tdata[7:0];
   assign req_key_byte  = req_tdata[15:8];
   assign req_tready    = (state_ff == ST_IDLE);
   assign req_xfer      = req_tvalid & req_tready;
   assign csr_ready     = 1'b1;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign rsp_free      = ~rsp_valid_ff | rsp_tready;

   // entry never written since reset or the last schedule reads as its own index
   assign perm_value = perm_rvld_ff ? perm_rdata_ff : perm_raddr_ff;

   // key position wraps after the effective key length
   always_comb begin
      if (key_length_ff == 9'd0) begin
         len_m1 = 9'd0;
      end else if (key_length_ff > MAX_LEN) begin
         len_m1 = MAX_LEN_M1;
      end else begin
         len_m1 = key_length_ff - 9'd1;
      end
   end
   assign kpos_last = (kpos_ff == len_m1[KW-1:0]);

   assign key_we = req_xfer && (req_cmd == CMD_LOAD) && ({1'b0, req_key_index} < MAX_LEN);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_cmd == CMD_SCHEDULE) begin
               state_in = ST_KS_READ_I;
            end else if (req_xfer && req_cmd == CMD_GENERATE) begin
               state_in = ST_GEN_READ_I;
            end
         end
         ST_KS_READ_I:    state_in = ST_KS_READ_J;
         ST_KS_READ_J:    state_in = ST_KS_WRITE_J;
         ST_KS_WRITE_J:   state_in = ST_KS_WRITE_I;
         ST_KS_WRITE_I: begin
            state_in = (cnt_ff == LAST_INDEX) ? ST_IDLE : ST_KS_READ_I;
         end
         ST_GEN_READ_I:   state_in = ST_GEN_READ_J;
         ST_GEN_READ_J:   state_in = ST_GEN_WRITE_J;
         ST_GEN_WRITE_J:  state_in = ST_GEN_WRITE_I;
         ST_GEN_WRITE_I:  state_in = ST_GEN_READ_SEL;
         ST_GEN_READ_SEL: state_in = ST_GEN_OUT;
         ST_GEN_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:         state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      i_in         = i_ff;
      j_in         = j_ff;
      cnt_in       = cnt_ff;
      kpos_in      = kpos_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      perm_re      = 1'b0;
      perm_raddr   = i_ff;
      perm_we      = 1'b0;
      perm_waddr   = j_ff;
      perm_wdata   = si_ff;
      perm_clear   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_cmd == CMD_SCHEDULE) begin
               perm_clear = 1'b1;
               cnt_in     = 8'd0;
               kpos_in    = '0;
               j_in       = 8'd0;
            end else if (req_xfer && req_cmd == CMD_GENERATE) begin
               i_in = 8'(i_ff + 8'd1);
            end
         end
         // key schedule: read entry n and the key byte
         ST_KS_READ_I: begin
            perm_re    = 1'b1;
            perm_raddr = cnt_ff;
         end
         // mix in the key byte, read the partner entry
         ST_KS_READ_J: begin
            si_in      = perm_value;
            j_in       = 8'(j_ff + key_rdata_ff + perm_value);
            perm_re    = 1'b1;
            perm_raddr = 8'(j_ff + key_rdata_ff + perm_value);
         end
         ST_KS_WRITE_J: begin
            sj_in      = perm_value;
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
         end
         ST_KS_WRITE_I: begin
            perm_we    = 1'b1;
            perm_waddr = cnt_ff;
            perm_wdata = sj_ff;
            cnt_in     = 8'(cnt_ff + 8'd1);
            kpos_in    = kpos_last ? '0 : KW'(kpos_ff + 1'b1);
            if (cnt_ff == LAST_INDEX) begin
               i_in = 8'd0;
               j_in = 8'd0;
            end
         end
         // keystream: read entry i
         ST_GEN_READ_I: begin
            perm_re    = 1'b1;
            perm_raddr = i_ff;
         end
         ST_GEN_READ_J: begin
            si_in      = perm_value;
            j_in       = 8'(j_ff + perm_value);
            perm_re    = 1'b1;
            perm_raddr = 8'(j_ff + perm_value);
         end
         ST_GEN_WRITE_J: begin
            sj_in      = perm_value;
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
         end
         ST_GEN_WRITE_I: begin
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = sj_ff;
         end
         // output lookup after both swap writes have landed
         ST_GEN_READ_SEL: begin
            perm_re    = 1'b1;
            perm_raddr = 8'(si_ff + sj_ff);
         end
         ST_GEN_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = perm_value;
            end
         end
         default: begin
            perm_re = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         i_ff          <= 8'd0;
         j_ff          <= 8'd0;
         cnt_ff        <= 8'd0;
         kpos_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         key_length_ff <= KEY_LENGTH_RESET;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         cnt_ff       <= cnt_in;
         kpos_ff      <= kpos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            key_length_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      rsp_data_ff <= rsp_data_in;
   end

   // written flags of the state table, cleared by reset and by a schedule
   always_ff @(posedge clock) begin
      if (reset) begin
         perm_valid_ff <= '0;
      end else if (perm_clear) begin
         perm_valid_ff <= '0;
      end else if (perm_we) begin
         perm_valid_ff[perm_waddr] <= 1'b1;
      end
   end

   // state table write port
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_waddr] <= perm_wdata;
      end
   end

   // state table read port
   always_ff @(posedge clock) begin
      if (perm_re) begin
         perm_rdata_ff <= perm_mem[perm_raddr];
         perm_rvld_ff  <= perm_valid_ff[perm_raddr];
         perm_raddr_ff <= perm_raddr;
      end
   end

   // key store
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[req_key_index[KW-1:0]] <= req_key_byte;
      end
   end

   always_ff @(posedge clock) begin
      key_rdata_ff <= key_mem[kpos_ff];
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import rc4_pkg::*;

   // command code the block ignores
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // long enough to cover one key schedule still in flight
   localparam int SETTLE_CYCLES = 1100;
   localparam int STALL_LIMIT = 12000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 145;
   localparam int MAX_REPORTS = 10;

   // one directed request with an optional hand-typed keystream byte
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] idx;
      logic [7:0] byt;
      logic       typed;
      logic [7:0] ks;
   } plan_row_type;

   localparam int PLAN_ROWS = 25;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // straight after reset the table is the identity: bytes 2 then 5
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b1, 8'h02},
      '{CMD_GENERATE, 8'hff, 8'hff, 1'b1, 8'h05},
      '{CMD_UNUSED,   8'hff, 8'hff, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h00, 8'h00, 1'b0, 8'h00},
      '{CMD_LOAD,     8'hff, 8'hff, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h01, 8'hff, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h02, 8'h80, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h03, 8'h01, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h04, 8'h5a, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h05, 8'ha5, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h06, 8'h3c, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h07, 8'hc3, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h08, 8'h7f, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h09, 8'h00, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h0a, 8'h12, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h0b, 8'h34, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h0c, 8'h56, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h0d, 8'h78, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h0e, 8'h9a, 1'b0, 8'h00},
      '{CMD_LOAD,     8'h0f, 8'hbc, 1'b0, 8'h00},
      '{CMD_SCHEDULE, 8'h00, 8'h00, 1'b0, 8'h00},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00},
      '{CMD_GENERATE, 8'hff, 8'hff, 1'b0, 8'h00},
      '{CMD_UNUSED,   8'h00, 8'h00, 1'b0, 8'h00},
      '{CMD_GENERATE, 8'h55, 8'haa, 1'b0, 8'h00}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [8:0]  csr_data;

   // predictor state
   logic [7:0] sbox [256];
   logic [7:0] key_mem [256];
   bit         key_seen [256];
   logic [7:0] ptr_i;
   logic [7:0] ptr_j;
   logic [8:0] klen_reg;

   logic [7:0] keystream_due [$];
   logic [7:0] due_byte;
   int         mismatches = 0;
   int         items_sent;
   int         stall_cycles = 0;
   bit         calm;

   rc4_keystream_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // key length as the schedule sees it
   function automatic int unsigned sched_len(logic [8:0] v);
      if (v == 9'd0) return 1;
      if (v > 9'd256) return 256;
      return 32'(v);
   endfunction

   function automatic bit key_ready(int unsigned len);
      for (int k = 0; k < len; k++)
         if (!key_seen[k]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic run_schedule();
      logic [7:0] mix;
      logic [7:0] t;
      int unsigned kpos;
      int unsigned len;
      len = sched_len(klen_reg);
      kpos = 0;
      mix = 8'd0;
      for (int n = 0; n < 256; n++) sbox[n] = n[7:0];
      for (int n = 0; n < 256; n++) begin
         mix = key_mem[kpos] + sbox[n] + mix;
         t = sbox[n];
         sbox[n] = sbox[mix];
         sbox[mix] = t;
         kpos = (kpos + 1) % len;
      end
      ptr_i = 8'd0;
      ptr_j = 8'd0;
   endtask

   task automatic advance_keystream(output logic [7:0] ks);
      logic [7:0] t;
      logic [7:0] sel;
      ptr_i = ptr_i + 8'd1;
      ptr_j = sbox[ptr_i] + ptr_j;
      t = sbox[ptr_i];
      sbox[ptr_i] = sbox[ptr_j];
      sbox[ptr_j] = t;
      sel = sbox[ptr_i] + sbox[ptr_j];
      ks = sbox[sel];
   endtask

   // predicted effect of one accepted request
   task automatic apply_request(input logic [1:0] cmd, input logic [7:0] idx,
                                input logic [7:0] byt, output bit gives,
                                output logic [7:0] ks);
      gives = 1'b0;
      ks = 8'd0;
      case (cmd)
         CMD_LOAD: begin
            key_mem[idx] = byt;
            key_seen[idx] = 1'b1;
         end
         CMD_SCHEDULE: run_schedule();
         CMD_GENERATE: begin
            advance_keystream(ks);
            gives = 1'b1;
         end
         default: ;
      endcase
   endtask

   // one request transfer, with random gaps ahead of it
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] idx,
                               input logic [7:0] byt, input bit typed,
                               input logic [7:0] typed_ks);
      bit gives;
      logic [7:0] ks;
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {byt, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(cmd, idx, byt, gives, ks);
      if (gives) keystream_due.push_back(typed ? typed_ks : ks);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   task automatic drain_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (keystream_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_key_length(input logic [8:0] v);
      drain_requests();
      // a load or schedule may still be in work after the last byte came
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      klen_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly load / schedule / generate runs, with noise between them
   task automatic run_phase(input int quota);
      int start;
      int unsigned len;
      int unsigned kind;
      logic [7:0] idx;
      start = items_sent;
      len = sched_len(klen_reg);
      while (items_sent - start < quota) begin
         if ($urandom_range(0, 99) < 70) begin
            // fresh key bytes, then fill any hole below the key length
            repeat ($urandom_range(0, (len < 8) ? len : 8)) begin
               idx = 8'($urandom_range(0, len - 1));
               send_request(CMD_LOAD, idx, 8'($urandom_range(0, 255)), 1'b0, 8'd0);
            end
            for (int k = 0; k < len; k++)
               if (!key_seen[k])
                  send_request(CMD_LOAD, k[7:0], 8'($urandom_range(0, 255)), 1'b0, 8'd0);
            if ($urandom_range(0, 99) < 5) drain_requests();
            send_request(CMD_SCHEDULE, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 1'b0, 8'd0);
            repeat ($urandom_range(1, 40))
               send_request(CMD_GENERATE, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 1'b0, 8'd0);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               kind = $urandom_range(0, 3);
               if (kind == 0)
                  send_request(CMD_LOAD, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 1'b0, 8'd0);
               else if (kind == 1)
                  send_request(CMD_UNUSED, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 1'b0, 8'd0);
               else if (kind == 2 && key_ready(len))
                  send_request(CMD_SCHEDULE, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 1'b0, 8'd0);
               else
                  send_request(CMD_GENERATE, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 1'b0, 8'd0);
            end
         end
      end
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 37);
   end

   // compare each keystream transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (keystream_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected keystream transfer: got %02h", rsp_tdata);
         end else begin
            due_byte = keystream_due.pop_front();
            if (rsp_tdata !== due_byte) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("keystream mismatch: expected %02h, got %02h",
                           due_byte, rsp_tdata);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [8:0] len_pick;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 16'd0;
      req_tuser = CMD_LOAD;
      csr_valid = 1'b0;
      csr_data = 9'd0;
      calm = 1'b0;
      items_sent = 0;
      for (int n = 0; n < 256; n++) begin
         sbox[n] = n[7:0];
         key_mem[n] = 8'd0;
         key_seen[n] = 1'b0;
      end
      ptr_i = 8'd0;
      ptr_j = 8'd0;
      klen_reg = KEY_LENGTH_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests at the reset key length
      for (int r = 0; r < PLAN_ROWS; r++)
         send_request(PLAN[r].cmd, PLAN[r].idx, PLAN[r].byt, PLAN[r].typed, PLAN[r].ks);

      // random phases over several key lengths, extremes first
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: len_pick = 9'd1;
            1: len_pick = 9'd0;
            2: len_pick = 9'd511;
            3: len_pick = 9'd256;
            4: len_pick = 9'd255;
            9: len_pick = 9'($urandom_range(0, 511));
            default: len_pick = 9'($urandom_range(1, 24));
         endcase
         write_key_length(len_pick);
         calm = (p == 5);
         run_phase(PHASE_ITEMS);
      end
      calm = 1'b0;

      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && keystream_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ rc4_keystream_generator.f @@
sv/rc4_pkg.sv
sv/rc4_keystream_generator.sv
bench/tb_top.sv
